@@ src/multi_task_window_watchdog_top_assert.svh @@
// ----------------------------------------------------------------------------
// multi_task_window_watchdog_top_assert.svh
// Assertion macros for the multi-task window watchdog; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef MULTI_TASK_WINDOW_WATCHDOG_TOP_ASSERT_SVH
`define MULTI_TASK_WINDOW_WATCHDOG_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// property checked on every clock edge outside reset
`define MTWW_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
   else $error("mtww assertion failed");
// property checked on every clock edge, reset included
`define MTWW_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
   else $error("mtww assertion failed");
`else
`define MTWW_ASSERT(label, clk, rst, prop)
`define MTWW_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

@@ src/mtww_pkg.sv @@
// ----------------------------------------------------------------------------
// mtww_pkg
// Shared types and constants of the multi-task window watchdog.
// ----------------------------------------------------------------------------
`default_nettype none

package mtww_pkg;

   // widths of the task masks and of a task index
   localparam int MASK_W = 32;
   localparam int IDX_W  = 5;

   // window length used when the register holds zero
   localparam logic [31:0] DEFAULT_WINDOW = 32'd1000;

   // item kinds
   typedef enum logic [2:0] {
      KIND_RESTART  = 3'd0,
      KIND_REGISTER = 3'd1,
      KIND_CHECKIN  = 3'd2,
      KIND_HOLD     = 3'd3,
      KIND_SERVICE  = 3'd4
   } kind_type;

   // controller to datapath commands
   typedef struct packed {
      logic             apply;     // transaction accepted, apply its kind
      logic             walk_rd;   // read one hold deadline
      logic [IDX_W-1:0] rd_addr;   // deadline being read
      logic             close;     // close the elapsed window
      logic             load_rsp;  // load the result register
      logic             feed;      // feed verdict for the result
   } ctrl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic latched_nz;   // a miss is latched
      logic running;      // current window not yet elapsed
      logic missing_nz;   // some task missed the window
   } ctrl_sts_type;

endpackage

`default_nettype wire

@@ src/mtww_req_if.sv @@
// ----------------------------------------------------------------------------
// mtww_req_if
// Request channel: item kind, task id, hold duration and current time.
// ----------------------------------------------------------------------------
`default_nettype none

interface mtww_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [5:0]  task_id;
   logic [31:0] hold_duration;
   logic [31:0] now;

   modport source (output valid, kind, task_id, hold_duration, now, input ready);
   modport sink   (input valid, kind, task_id, hold_duration, now, output ready);
endinterface

`default_nettype wire

@@ src/mtww_rsp_if.sv @@
// ----------------------------------------------------------------------------
// mtww_rsp_if
// Response channel: feed verdict, latched miss mask and window counters.
// ----------------------------------------------------------------------------
`default_nettype none

interface mtww_rsp_if;
   logic        valid;
   logic        ready;
   logic        feed_ok;
   logic [31:0] missed_mask;
   logic [31:0] ok_windows;
   logic [31:0] failed_windows;

   modport source (output valid, feed_ok, missed_mask, ok_windows, failed_windows,
                   input ready);
   modport sink   (input valid, feed_ok, missed_mask, ok_windows, failed_windows,
                   output ready);
endinterface

`default_nettype wire

@@ src/mtww_csr_if.sv @@
// ----------------------------------------------------------------------------
// mtww_csr_if
// Configuration write channel carrying the window length.
// ----------------------------------------------------------------------------
`default_nettype none

interface mtww_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] window_length;

   modport source (output valid, window_length, input ready);
   modport sink   (input valid, window_length, output ready);
endinterface

`default_nettype wire

@@ src/mtww_ctrl.sv @@
// ----------------------------------------------------------------------------
// mtww_ctrl
// Controller: accepts transactions, sequences the deadline walk of a service
// and hands results to the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module mtww_ctrl #(
   parameter int TASKS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [2:0]            req_kind,
   output logic                  req_ready,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   input  mtww_pkg::ctrl_sts_type sts,
   output mtww_pkg::ctrl_cmd_type cmd
);
   import mtww_pkg::*;

   localparam int AW = (TASKS > 1) ? $clog2(TASKS) : 1;
   localparam logic [AW-1:0] LAST_IDX = AW'(TASKS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_WALK,
      ST_DRAIN,
      ST_CLOSE,
      ST_RESULT
   } fsm_state_type;

   fsm_state_type state_ff;
   logic [AW-1:0] idx_ff;
   logic          feed_ff;
   logic          rsp_valid_ff;

   // commands decoded from state
   always_comb begin
      req_ready    = (state_ff == ST_IDLE);
      cmd.apply    = req_valid && req_ready;
      cmd.walk_rd  = (state_ff == ST_WALK);
      cmd.rd_addr  = IDX_W'(idx_ff);
      cmd.close    = (state_ff == ST_CLOSE);
      cmd.load_rsp = (state_ff == ST_RESULT) && (!rsp_valid_ff || rsp_ready);
      cmd.feed     = feed_ff;
      rsp_valid    = rsp_valid_ff;
   end

   // state machine with registered feed verdict and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         feed_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // response valid: set on load, cleared once taken
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (cmd.apply && (req_kind == KIND_SERVICE)) begin
                  state_ff <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               if (sts.latched_nz) begin
                  feed_ff  <= 1'b0;
                  state_ff <= ST_RESULT;
               end else if (sts.running) begin
                  feed_ff  <= 1'b1;
                  state_ff <= ST_RESULT;
               end else begin
                  idx_ff   <= '0;
                  state_ff <= ST_WALK;
               end
            end
            ST_WALK: begin
               if (idx_ff == LAST_IDX) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  idx_ff <= idx_ff + AW'(1);
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_CLOSE;
            end
            ST_CLOSE: begin
               feed_ff  <= !sts.missing_nz;
               state_ff <= ST_RESULT;
            end
            ST_RESULT: begin
               if (cmd.load_rsp) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

@@ src/mtww_dp.sv @@
// ----------------------------------------------------------------------------
// mtww_dp
// Datapath: task masks, hold deadline memory, window timing, counters and
// the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module mtww_dp #(
   parameter int TASKS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [2:0]             req_kind,
   input  logic [5:0]             req_task_id,
   input  logic [31:0]            req_hold_duration,
   input  logic [31:0]            req_now,
   input  logic                   csr_we,
   input  logic [31:0]            csr_window_length,
   input  mtww_pkg::ctrl_cmd_type cmd,
   output mtww_pkg::ctrl_sts_type sts,
   output logic                   rsp_feed_ok,
   output logic [31:0]            rsp_missed_mask,
   output logic [31:0]            rsp_ok_windows,
   output logic [31:0]            rsp_failed_windows
);
   import mtww_pkg::*;

   localparam int AW = (TASKS > 1) ? $clog2(TASKS) : 1;

   logic [31:0]       window_len_ff;
   logic [MASK_W-1:0] registered_ff;
   logic [MASK_W-1:0] seen_ff;
   logic [MASK_W-1:0] held_ff;
   logic [MASK_W-1:0] exempt_ff;
   logic [MASK_W-1:0] latched_ff;
   logic [31:0]       begin_ff;
   logic [31:0]       ok_cnt_ff;
   logic [31:0]       fail_cnt_ff;
   logic [31:0]       now_ff;
   logic [31:0]       rd_data_ff;
   logic [AW-1:0]     rd_idx_ff;
   logic              rd_vld_ff;
   logic              feed_ff;
   logic [31:0]       rsp_missed_ff;
   logic [31:0]       rsp_ok_ff;
   logic [31:0]       rsp_fail_ff;

   // hold deadlines, one per task
   logic [31:0] hold_mem [TASKS];

   logic              id_valid;
   logic [MASK_W-1:0] id_bit;
   logic [31:0]       eff_len;
   logic [31:0]       elapsed;
   logic [31:0]       hold_left;
   logic              hold_live;
   logic [MASK_W-1:0] missing;

   // task decode and window arithmetic
   always_comb begin
      id_valid  = ({1'b0, req_task_id} < 7'(TASKS));
      id_bit    = id_valid ? (MASK_W'(1) << req_task_id[IDX_W-1:0]) : '0;
      eff_len   = (window_len_ff == '0) ? DEFAULT_WINDOW : window_len_ff;
      elapsed   = now_ff - begin_ff;
      hold_left = rd_data_ff - now_ff;
      hold_live = (hold_left != '0) && !hold_left[31];
      missing   = registered_ff & ~seen_ff & ~exempt_ff;
      sts.latched_nz = (latched_ff != '0);
      sts.running    = (elapsed < eff_len);
      sts.missing_nz = (missing != '0);
   end

   // control state: masks, window start, counters
   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff <= DEFAULT_WINDOW;
         registered_ff <= '0;
         seen_ff       <= '0;
         held_ff       <= '0;
         exempt_ff     <= '0;
         latched_ff    <= '0;
         begin_ff      <= '0;
         ok_cnt_ff     <= '0;
         fail_cnt_ff   <= '0;
         rd_vld_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            window_len_ff <= csr_window_length;
         end

         // exemption bit of the deadline read last cycle
         rd_vld_ff <= cmd.walk_rd;
         if (rd_vld_ff) begin
            exempt_ff[IDX_W'(rd_idx_ff)] <= held_ff[IDX_W'(rd_idx_ff)] && hold_live;
         end

         // accepted transaction
         if (cmd.apply) begin
            unique case (kind_type'(req_kind))
               KIND_RESTART: begin
                  registered_ff <= '0;
                  seen_ff       <= '0;
                  held_ff       <= '0;
                  latched_ff    <= '0;
                  ok_cnt_ff     <= '0;
                  fail_cnt_ff   <= '0;
                  begin_ff      <= req_now;
               end
               KIND_REGISTER: begin
                  registered_ff <= registered_ff | id_bit;
                  seen_ff       <= seen_ff | id_bit;
               end
               KIND_CHECKIN: begin
                  seen_ff <= seen_ff | id_bit;
                  held_ff <= held_ff & ~id_bit;
               end
               KIND_HOLD: begin
                  held_ff <= held_ff | id_bit;
               end
               KIND_SERVICE: begin
               end
               default: begin
               end
            endcase
         end

         // window close after the walk
         if (cmd.close) begin
            if (missing != '0) begin
               latched_ff  <= missing;
               fail_cnt_ff <= fail_cnt_ff + 32'd1;
            end else begin
               ok_cnt_ff <= ok_cnt_ff + 32'd1;
               seen_ff   <= '0;
               begin_ff  <= now_ff;
            end
         end
      end
   end

   // deadline memory: write on hold, registered read during the walk
   always_ff @(posedge clock) begin
      if (cmd.apply && (req_kind == KIND_HOLD) && id_valid) begin
         hold_mem[req_task_id[AW-1:0]] <= req_now + req_hold_duration;
      end
      if (cmd.walk_rd) begin
         rd_data_ff <= hold_mem[cmd.rd_addr[AW-1:0]];
         rd_idx_ff  <= cmd.rd_addr[AW-1:0];
      end
   end

   // service time and response payload
   always_ff @(posedge clock) begin
      if (cmd.apply && (req_kind == KIND_SERVICE)) begin
         now_ff <= req_now;
      end
      if (cmd.load_rsp) begin
         feed_ff       <= cmd.feed;
         rsp_missed_ff <= latched_ff;
         rsp_ok_ff     <= ok_cnt_ff;
         rsp_fail_ff   <= fail_cnt_ff;
      end
   end

   assign rsp_feed_ok        = feed_ff;
   assign rsp_missed_mask    = rsp_missed_ff;
   assign rsp_ok_windows     = rsp_ok_ff;
   assign rsp_failed_windows = rsp_fail_ff;

endmodule

`default_nettype wire

@@ src/multi_task_window_watchdog_top.sv @@
// ----------------------------------------------------------------------------
// multi_task_window_watchdog_top
// Windowed check-in watchdog for up to TASKS software tasks.
// ----------------------------------------------------------------------------
// Restart, register, checkin and hold transactions are applied in the cycle
// they are accepted, so one can be taken every cycle while the block is idle.
// A service transaction holds the request side through the decide state when a
// miss is latched or the window is still running, and on through the walk,
// drain and close states when the window has elapsed: the hold deadline memory
// has one read port and the walk reads one task's deadline per cycle. Its
// response is loaded in the result state once the response register is free;
// until then no request is taken. A waiting response stalls only the load of
// the next service's response, not other requests. The configuration port is
// always ready.
`default_nettype none
`include "multi_task_window_watchdog_top_assert.svh"

module multi_task_window_watchdog_top #(
   parameter int TASKS = 32
) (
   input  logic       clock,
   input  logic       reset,
   mtww_req_if.sink   req_chan,
   mtww_rsp_if.source rsp_chan,
   mtww_csr_if.sink   csr_chan
);
   import mtww_pkg::*;

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   // configuration writes are always taken
   assign csr_chan.ready = 1'b1;

   // controller
   mtww_ctrl #(
      .TASKS (TASKS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_kind  (req_chan.kind),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath
   mtww_dp #(
      .TASKS (TASKS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_kind           (req_chan.kind),
      .req_task_id        (req_chan.task_id),
      .req_hold_duration  (req_chan.hold_duration),
      .req_now            (req_chan.now),
      .csr_we             (csr_chan.valid && csr_chan.ready),
      .csr_window_length  (csr_chan.window_length),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_feed_ok        (rsp_chan.feed_ok),
      .rsp_missed_mask    (rsp_chan.missed_mask),
      .rsp_ok_windows     (rsp_chan.ok_windows),
      .rsp_failed_windows (rsp_chan.failed_windows)
   );

   // service blocks further requests until its response is loaded
   `MTWW_ASSERT(a_service_blocks, clock, reset,
      (cmd.apply && (req_chan.kind == KIND_SERVICE)) |=> !req_chan.ready)
   // no deadline read while requests are taken
   `MTWW_ASSERT(a_walk_not_idle, clock, reset, cmd.walk_rd |-> !req_chan.ready)
   // a window is never closed over a latched miss
   `MTWW_ASSERT(a_close_unlatched, clock, reset, cmd.close |-> !sts.latched_nz)
   // response load and request apply never coincide
   `MTWW_ASSERT_ALWAYS(a_load_apply_apart, clock, !(cmd.apply && cmd.load_rsp))

endmodule

`default_nettype wire

@@ sim/mtww_checker.sv @@
// ----------------------------------------------------------------------------
// mtww_checker
// Watches the request, response and configuration channels of the multi-task
// window watchdog. It keeps its own copy of the task masks, hold deadlines,
// window start and counters, works out the verdict of every accepted service
// transaction, and compares each accepted response field by field against
// the oldest verdict still waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module mtww_checker
   import mtww_pkg::*;
#(
   parameter int TASKS = 32
) (
   input  logic        clock,
   input  logic        reset,
   mtww_req_if         req_mon,
   mtww_rsp_if         rsp_mon,
   mtww_csr_if         csr_mon,
   output int unsigned mismatches,
   output int unsigned outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   // one service verdict as it appears on the response channel
   typedef struct packed {
      logic        feed_ok;
      logic [31:0] missed_mask;
      logic [31:0] ok_windows;
      logic [31:0] failed_windows;
   } feed_verdict_type;

   // shadow of the watchdog state
   logic [31:0] window_len;
   logic [31:0] registered;
   logic [31:0] seen;
   logic [31:0] held;
   logic [31:0] hold_until [32];
   logic [31:0] win_start;
   logic [31:0] latched_miss;
   logic [31:0] ok_cnt;
   logic [31:0] fail_cnt;

   feed_verdict_type pending_verdicts[$];
   int unsigned      responses_seen;

   // print one line per mismatch and count it
   task automatic flag_mismatch(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      mismatches++;
      $display("[%0t] mismatch on response %0d, %s: expected %h, got %h",
               $realtime, responses_seen, field, want, got);
   endtask

   // apply one request transaction to the shadow state
   task automatic apply_request(input logic [2:0] kind, input logic [5:0] id,
                                input logic [31:0] dur, input logic [31:0] now);
      logic [31:0]      task_bit;
      logic [31:0]      len_eff;
      logic [31:0]      exempt;
      logic [31:0]      missing;
      logic [31:0]      slack;
      feed_verdict_type v;
      task_bit = (id < TASKS) ? (32'd1 << id[4:0]) : 32'd0;
      case (kind)
         KIND_RESTART: begin
            registered   = '0;
            seen         = '0;
            held         = '0;
            latched_miss = '0;
            ok_cnt       = '0;
            fail_cnt     = '0;
            win_start    = now;
         end
         KIND_REGISTER: begin
            registered |= task_bit;
            seen       |= task_bit;
         end
         KIND_CHECKIN: begin
            seen |= task_bit;
            held &= ~task_bit;
         end
         KIND_HOLD: begin
            if (id < TASKS) begin
               held |= task_bit;
               hold_until[id[4:0]] = now + dur;
            end
         end
         KIND_SERVICE: begin
            len_eff = (window_len == 32'd0) ? DEFAULT_WINDOW : window_len;
            if (latched_miss != 32'd0) begin
               v.feed_ok = 1'b0;
            end else if (32'(now - win_start) < len_eff) begin
               v.feed_ok = 1'b1;
            end else begin
               // a hold counts while its deadline lies strictly ahead of now
               exempt = '0;
               for (int i = 0; i < TASKS; i++) begin
                  slack = hold_until[i] - now;
                  if (held[i] && slack != 32'd0 && !slack[31])
                     exempt[i] = 1'b1;
               end
               missing = registered & ~seen & ~exempt;
               if (missing != 32'd0) begin
                  latched_miss = missing;
                  fail_cnt     = fail_cnt + 32'd1;
                  v.feed_ok    = 1'b0;
               end else begin
                  ok_cnt    = ok_cnt + 32'd1;
                  seen      = '0;
                  win_start = now;
                  v.feed_ok = 1'b1;
               end
            end
            v.missed_mask    = latched_miss;
            v.ok_windows     = ok_cnt;
            v.failed_windows = fail_cnt;
            pending_verdicts.push_back(v);
         end
         default: ;
      endcase
   endtask

   // compare one response transaction with the oldest verdict
   task automatic check_response(input feed_verdict_type got);
      feed_verdict_type want;
      responses_seen++;
      if (pending_verdicts.size() == 0) begin
         flag_mismatch("response with no service outstanding", 32'd0, 32'd0);
         return;
      end
      want = pending_verdicts.pop_front();
      if (got.feed_ok !== want.feed_ok)
         flag_mismatch("feed_ok", 32'(want.feed_ok), 32'(got.feed_ok));
      if (got.missed_mask !== want.missed_mask)
         flag_mismatch("missed_mask", want.missed_mask, got.missed_mask);
      if (got.ok_windows !== want.ok_windows)
         flag_mismatch("ok_windows", want.ok_windows, got.ok_windows);
      if (got.failed_windows !== want.failed_windows)
         flag_mismatch("failed_windows", want.failed_windows, got.failed_windows);
   endtask

   initial begin
      mismatches     = 0;
      outstanding    = 0;
      responses_seen = 0;
   end

   // sample all channels at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         window_len   = DEFAULT_WINDOW;
         registered   = '0;
         seen         = '0;
         held         = '0;
         win_start    = '0;
         latched_miss = '0;
         ok_cnt       = '0;
         fail_cnt     = '0;
         pending_verdicts.delete();
      end else begin
         // responses first: one leaving now belongs to an earlier service
         if (rsp_mon.valid && rsp_mon.ready)
            check_response({rsp_mon.feed_ok, rsp_mon.missed_mask,
                            rsp_mon.ok_windows, rsp_mon.failed_windows});
         if (csr_mon.valid && csr_mon.ready)
            window_len = csr_mon.window_length;
         if (req_mon.valid && req_mon.ready)
            apply_request(req_mon.kind, req_mon.task_id, req_mon.hold_duration,
                          req_mon.now);
      end
      outstanding = pending_verdicts.size();
   end

endmodule

`default_nettype wire

@@ sim/multi_task_window_watchdog_top_tb.sv @@
// ----------------------------------------------------------------------------
// multi_task_window_watchdog_top_tb
// Stimulus and verdict for the multi-task window watchdog.
// ----------------------------------------------------------------------------
// A directed opening hits the window edges, hold expiry on both sides of the
// signed compare, ignored task ids and kinds, and a latched miss. Random
// episodes then restart, register tasks and walk several windows with
// check-ins, covering and expiring holds and the odd missing task, mixed
// with random noise. The window length is rewritten between phases, and the
// sender and receiver idle under three profiles with one long receive stall.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_task_window_watchdog_top_tb;
   import mtww_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TASKS = 32;
   localparam int PHASE_ITEMS = 150;
   localparam int STALL_CYCLES = 400;

   // kinds the block ignores
   localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
   localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;

   logic clock;
   logic reset;

   mtww_req_if req_chan ();
   mtww_rsp_if rsp_chan ();
   mtww_csr_if csr_chan ();

   int unsigned mismatches;
   int unsigned pending;

   int          tx_idle_pct;
   int          rx_idle_pct;
   bit          rsp_blocked;
   int          phase_no;
   int unsigned items_sent;
   int unsigned items_counted;
   int unsigned services_sent;
   int unsigned window_writes;
   logic [31:0] cur_window;
   logic [31:0] window_plan [6];

   multi_task_window_watchdog_top #(
      .TASKS(TASKS)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_chan(csr_chan)
   );

   mtww_checker #(
      .TASKS(TASKS)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .csr_mon    (csr_chan),
      .mismatches (mismatches),
      .outstanding(pending)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // response ready, with random idling and the long hold-off
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= !rsp_blocked && ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   // long receiver stall while the sender keeps offering transactions
   initial begin
      rsp_blocked = 1'b0;
      wait (phase_no == 4);
      rsp_blocked = 1'b1;
      repeat (STALL_CYCLES) @(negedge clock);
      rsp_blocked = 1'b0;
   end

   // run limit
   initial begin
      #8_000_000;
      $display("timeout with %0d responses outstanding", pending);
      $display("multi_task_window_watchdog_top verification failed");
      $finish;
   end

   // offer one request transaction and wait for its acceptance
   task automatic drive_item(input logic [2:0] kind, input logic [5:0] id,
                             input logic [31:0] dur, input logic [31:0] now);
      @(negedge clock);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.kind          <= kind;
      req_chan.task_id       <= id;
      req_chan.hold_duration <= dur;
      req_chan.now           <= now;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
      if (kind == KIND_SERVICE)
         services_sent++;
      if (kind == KIND_RESTART || kind == KIND_SERVICE ||
          (kind <= KIND_HOLD && id < TASKS))
         items_counted++;
   endtask

   // stop offering requests
   task automatic idle_requests();
      @(negedge clock);
      req_chan.valid <= 1'b0;
   endtask

   // rewrite the window length once all responses are back
   task automatic write_window(input logic [31:0] value);
      idle_requests();
      while (pending != 0) @(negedge clock);
      repeat (TASKS + 8) @(negedge clock);
      csr_chan.valid         <= 1'b1;
      csr_chan.window_length <= value;
      do @(posedge clock); while (!csr_chan.ready);
      @(negedge clock);
      csr_chan.valid <= 1'b0;
      cur_window = value;
      window_writes++;
   endtask

   // a few fully random transactions
   task automatic noise_burst();
      repeat ($urandom_range(1, 4))
         drive_item(3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)), $urandom(),
                    $urandom());
   endtask

   // restart, register tasks, then walk a few windows
   task automatic run_episode();
      logic [31:0] win_start;
      logic [31:0] close_at;
      logic [31:0] len_eff;
      logic [31:0] span;
      logic [31:0] t_in;
      logic [31:0] extra;
      logic [31:0] reg_set;
      logic [5:0]  id;
      bit          missed;
      int          fate;
      int          n_windows;
      win_start = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 2000)
                                              : $urandom();
      drive_item(KIND_RESTART, 6'($urandom_range(0, 63)), $urandom(), win_start);
      reg_set = '0;
      repeat ($urandom_range(1, 8)) begin
         id = ($urandom_range(0, 15) == 0) ? 6'($urandom_range(32, 63))
                                           : 6'($urandom_range(0, 31));
         drive_item(KIND_REGISTER, id, $urandom(), win_start + $urandom_range(0, 3));
         if (id < TASKS)
            reg_set[id[4:0]] = 1'b1;
      end
      len_eff = (cur_window == 32'd0) ? DEFAULT_WINDOW : cur_window;
      span    = (len_eff > 32'd400) ? 32'd400 : len_eff - 32'd1;
      n_windows = $urandom_range(2, 5);
      for (int w = 0; w < n_windows; w++) begin
         extra    = (len_eff < 32'h8000_0000) ? $urandom_range(0, 20) : 32'd0;
         close_at = win_start + len_eff + extra;
         missed   = 1'b0;
         for (int i = 0; i < TASKS; i++) begin
            if (reg_set[i]) begin
               fate = $urandom_range(0, 99);
               t_in = win_start + $urandom_range(0, span);
               if (fate < 70) begin
                  drive_item(KIND_CHECKIN, 6'(i), $urandom(), t_in);
               end else if (fate < 80) begin
                  // hold ended by a later checkin
                  drive_item(KIND_HOLD, 6'(i), $urandom(), t_in);
                  drive_item(KIND_CHECKIN, 6'(i), $urandom(), t_in);
               end else if (fate < 92) begin
                  // hold reaching past the close
                  drive_item(KIND_HOLD, 6'(i), close_at - t_in + $urandom_range(1, 1000),
                             t_in);
               end else if (fate < 96) begin
                  // hold ending at or just before the close
                  drive_item(KIND_HOLD, 6'(i), close_at - t_in - $urandom_range(0, 5),
                             t_in);
                  missed = 1'b1;
               end else begin
                  missed = 1'b1;
               end
            end
         end
         if ($urandom_range(0, 2) == 0)
            drive_item(KIND_SERVICE, 6'($urandom_range(0, 63)), $urandom(),
                       win_start + $urandom_range(0, len_eff - 32'd1));
         drive_item(KIND_SERVICE, 6'($urandom_range(0, 63)), $urandom(), close_at);
         if (missed) begin
            drive_item(KIND_SERVICE, 6'($urandom_range(0, 63)), $urandom(),
                       close_at + $urandom_range(0, 5000));
            break;
         end
         win_start = close_at;
      end
   endtask

   // stimulus
   initial begin
      logic [31:0] t0;
      reset                  = 1'b1;
      req_chan.valid         = 1'b0;
      req_chan.kind          = KIND_RESTART;
      req_chan.task_id       = '0;
      req_chan.hold_duration = '0;
      req_chan.now           = '0;
      csr_chan.valid         = 1'b0;
      csr_chan.window_length = '0;
      tx_idle_pct   = 27;
      rx_idle_pct   = 77;
      phase_no      = -1;
      items_sent    = 0;
      items_counted = 0;
      services_sent = 0;
      window_writes = 0;
      cur_window    = DEFAULT_WINDOW;
      window_plan[0] = 32'd0;
      window_plan[1] = 32'd1;
      window_plan[2] = 32'hFFFF_FFFF;
      window_plan[3] = 32'd250;
      window_plan[4] = 32'h8000_0000;
      window_plan[5] = $urandom_range(2, 3000);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: window edges at the reset length, holds, ignored items
      drive_item(KIND_SERVICE, 6'd0, 32'd0, 32'd999);
      drive_item(KIND_REGISTER, 6'd0, 32'd0, 32'd0);
      drive_item(KIND_REGISTER, 6'd31, 32'd0, 32'd0);
      drive_item(KIND_REGISTER, 6'd63, 32'd0, 32'd0);
      drive_item(KIND_CHECKIN, 6'd0, 32'd0, 32'd10);
      drive_item(KIND_HOLD, 6'd31, 32'd2000, 32'd20);
      drive_item(KIND_HOLD, 6'd40, 32'd5, 32'd20);
      drive_item(KIND_SPARE_FIRST, 6'd1, 32'hFFFF_FFFF, 32'd30);
      drive_item(KIND_SPARE_LAST, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      drive_item(KIND_SERVICE, 6'd63, 32'hFFFF_FFFF, 32'd1000);
      drive_item(KIND_HOLD, 6'd31, 32'd1000, 32'd1020);
      drive_item(KIND_CHECKIN, 6'd0, 32'd0, 32'd1500);
      // hold ends exactly at the service time, so task 31 misses
      drive_item(KIND_SERVICE, 6'd0, 32'd0, 32'd2020);
      drive_item(KIND_SERVICE, 6'd0, 32'd0, 32'd2500);
      // wrapping times and the signed hold compare at its limits
      t0 = 32'hFFFF_FF00;
      drive_item(KIND_RESTART, 6'd17, 32'd0, t0);
      drive_item(KIND_REGISTER, 6'd5, 32'd0, t0);
      drive_item(KIND_REGISTER, 6'd6, 32'd0, t0);
      drive_item(KIND_HOLD, 6'd5, 32'h7FFF_FFFF, t0);
      drive_item(KIND_SERVICE, 6'd5, 32'd0, t0 + 32'd1000);
      drive_item(KIND_CHECKIN, 6'd6, 32'd0, t0 + 32'd1500);
      drive_item(KIND_HOLD, 6'd5, 32'h8000_0000, t0 + 32'd2000);
      drive_item(KIND_SERVICE, 6'd5, 32'd0, t0 + 32'd2000);
      drive_item(KIND_RESTART, 6'd0, 32'd0, 32'd0);
      drive_item(KIND_SERVICE, 6'd0, 32'd0, 32'hFFFF_FFFF);

      // random phases under three idling profiles
      for (int phase = 0; phase < 6; phase++) begin
         write_window(window_plan[phase]);
         case (phase / 2)
            0: begin
               tx_idle_pct = 27;
               rx_idle_pct = 77;
            end
            1: begin
               tx_idle_pct = 77;
               rx_idle_pct = 27;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         phase_no = phase;
         t0 = items_counted + PHASE_ITEMS;
         while (items_counted < t0) begin
            if ($urandom_range(0, 9) == 0)
               noise_burst();
            else
               run_episode();
         end
      end

      // drain and give the verdict
      idle_requests();
      while (pending != 0) @(negedge clock);
      repeat (TASKS + 10) @(negedge clock);
      $display("covered %0d request transactions, %0d of them service, over %0d window lengths",
               items_sent, services_sent, window_writes + 1);
      $display("window lengths included zero, one, half range and all ones");
      if (mismatches == 0 && pending == 0)
         $display("multi_task_window_watchdog_top verification clean");
      else
         $display("multi_task_window_watchdog_top verification failed");
      $finish;
   end

endmodule

`default_nettype wire
